>>> design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/bam_pkg.sv
package bam_pkg;

  localparam int FUNC_W = 3;
  localparam int BLK_W  = 7;
  localparam int LEN_W  = 8;
  localparam int STAT_W = 3;
  localparam int SUM_W  = LEN_W + 1;
  localparam int GRP_SZ = 8;
  localparam int GIDX_W = 3;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_CONTIG = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LINKED = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INDEX  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DATA   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PENDING = 3'd0;
  localparam logic [STAT_W-1:0] ST_COMMIT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_USED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_EQIDX   = 3'd4;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd6;

  typedef enum logic [1:0] {
    TX_IDLE,
    TX_LINKED,
    TX_INDEXED,
    TX_FAILED
  } txn_state_t;

  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic latch;  // capture the incoming item and its range search
    logic exec;   // apply the item to the maps and load the result
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being drained
  } dp_stat_t;

endpackage

>>> design/bam_ctrl.sv
module bam_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bam_pkg::dp_stat_t stat,
  output bam_pkg::ctl_cmd_t cmd
);
  import bam_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // hold until the result register can take the item's result
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

>>> design/bam_datapath.sv
module bam_datapath #(
  parameter int NUM_BLOCKS = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bam_pkg::ctl_cmd_t           cmd,
  output bam_pkg::dp_stat_t           stat,
  input  logic [bam_pkg::FUNC_W-1:0]  in_func,
  input  logic [bam_pkg::BLK_W-1:0]   in_block,
  input  logic [bam_pkg::LEN_W-1:0]   in_length,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bam_pkg::STAT_W-1:0]  out_status,
  output logic [bam_pkg::BLK_W-1:0]   out_fault_block
);
  import bam_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int NGRP  = (NUM_BLOCKS + GRP_SZ - 1) / GRP_SZ;
  localparam int PAD_W = NGRP * GRP_SZ;
  localparam logic [SUM_W-1:0] NB_S = SUM_W'(NUM_BLOCKS);

  // Item registers
  logic [FUNC_W-1:0]     func_r;
  logic [BLK_W-1:0]      blk_r;
  logic [LEN_W-1:0]      len_r;
  logic                  last_r;
  logic [NUM_BLOCKS-1:0] mask_r, mask_nxt;
  logic [NGRP-1:0]       grp_any_r, grp_any_nxt;
  logic [GIDX_W-1:0]     grp_idx_r [NGRP];
  logic [GIDX_W-1:0]     grp_idx_nxt [NGRP];

  // Map state
  logic [NUM_BLOCKS-1:0] used_r, used_nxt;
  logic [NUM_BLOCKS-1:0] pend_r, pend_nxt;
  logic [BLK_W-1:0]      idx_r, idx_nxt;
  txn_state_t            txn_r, txn_nxt;

  // Result register
  logic                  out_valid_r;
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic [BLK_W-1:0]      fault_r, fault_nxt;

  logic [SUM_W-1:0]      end_s;
  logic [PAD_W-1:0]      hits_pad;

  // Range mask and grouped first-hit search on the incoming item
  always_comb begin
    end_s = SUM_W'(in_block) + SUM_W'(in_length);
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      mask_nxt[i] = (SUM_W'(i) >= SUM_W'(in_block)) && (SUM_W'(i) < end_s);
    end
    hits_pad = PAD_W'(used_r & mask_nxt);
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = |hits_pad[g*GRP_SZ +: GRP_SZ];
      grp_idx_nxt[g] = '0;
      for (int j = GRP_SZ - 1; j >= 0; j--) begin
        if (hits_pad[g*GRP_SZ + j]) begin
          grp_idx_nxt[g] = GIDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r    <= in_func;
      blk_r     <= in_block;
      len_r     <= in_length;
      last_r    <= in_last;
      mask_r    <= mask_nxt;
      grp_any_r <= grp_any_nxt;
      for (int g = 0; g < NGRP; g++) begin
        grp_idx_r[g] <= grp_idx_nxt[g];
      end
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      fault_r  <= fault_nxt;
    end
  end

  // Apply the latched item
  always_comb begin
    logic             blk_bad;
    logic             range_bad;
    logic [IDX_W-1:0] bix;
    logic [BLK_W-1:0] first;
    logic             fail;
    logic [STAT_W-1:0] fcode;
    txn_state_t       open_st;

    used_nxt   = used_r;
    pend_nxt   = pend_r;
    idx_nxt    = idx_r;
    txn_nxt    = txn_r;
    status_nxt = ST_IGNORED;
    fault_nxt  = blk_r;
    fail       = 1'b0;
    fcode      = ST_RANGE;
    open_st    = (func_r == FN_LINKED) ? TX_LINKED : TX_INDEXED;
    bix        = blk_r[IDX_W-1:0];
    blk_bad    = SUM_W'(blk_r) >= NB_S;
    range_bad  = blk_bad || ((SUM_W'(blk_r) + SUM_W'(len_r)) > NB_S);

    first = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        first = BLK_W'(g * GRP_SZ) + BLK_W'(grp_idx_r[g]);
      end
    end

    case (func_r)
      FN_CONTIG: begin
        pend_nxt = '0;
        txn_nxt  = TX_IDLE;
        if (range_bad) begin
          status_nxt = ST_RANGE;
        end else if (|grp_any_r) begin
          status_nxt = ST_USED;
          fault_nxt  = first;
        end else begin
          status_nxt = ST_COMMIT;
          used_nxt   = used_r | mask_r;
        end
      end
      FN_CLEAR: begin
        pend_nxt   = '0;
        txn_nxt    = TX_IDLE;
        used_nxt   = '0;
        idx_nxt    = '0;
        status_nxt = ST_CLEARED;
      end
      FN_LINKED, FN_INDEX, FN_DATA: begin
        if (txn_r == TX_FAILED) begin
          if (last_r) begin
            txn_nxt = TX_IDLE;
          end
        end else if (func_r == FN_DATA && txn_r != TX_INDEXED) begin
          status_nxt = ST_IGNORED;
        end else begin
          // a new list drops whatever transaction was open
          if (func_r == FN_INDEX || (func_r == FN_LINKED && txn_r != TX_LINKED)) begin
            pend_nxt = '0;
            txn_nxt  = TX_IDLE;
          end
          if (blk_bad) begin
            fail  = 1'b1;
            fcode = ST_RANGE;
          end else if (used_r[bix]) begin
            fail  = 1'b1;
            fcode = ST_USED;
          end else if (func_r == FN_DATA && blk_r == idx_r) begin
            fail  = 1'b1;
            fcode = ST_EQIDX;
          end
          if (fail) begin
            status_nxt = fcode;
            if (last_r) begin
              pend_nxt = '0;
              txn_nxt  = TX_IDLE;
            end else begin
              txn_nxt = TX_FAILED;
            end
          end else begin
            if (func_r == FN_INDEX) begin
              idx_nxt = blk_r;
            end
            pend_nxt[bix] = 1'b1;
            if (last_r) begin
              used_nxt   = used_r | pend_nxt;
              pend_nxt   = '0;
              txn_nxt    = TX_IDLE;
              status_nxt = ST_COMMIT;
            end else begin
              txn_nxt    = open_st;
              status_nxt = ST_PENDING;
            end
          end
        end
      end
      default: begin
        status_nxt = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      pend_r      <= '0;
      idx_r       <= '0;
      txn_r       <= TX_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        used_r <= used_nxt;
        pend_r <= pend_nxt;
        idx_r  <= idx_nxt;
        txn_r  <= txn_nxt;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_fault_block = fault_r;

endmodule

>>> design/block_allocation_bitmap.sv
// Block allocation bitmap: a used bit per storage block, with all-or-nothing
// contiguous, linked and indexed allocation transactions and a clear command.
// Input channel (in_valid/in_ready): one item per request carrying in_func,
// in_block, in_length and in_last. Result channel (out_valid/out_ready):
// exactly one result item per input item, out_status and out_fault_block.
// Timing: an accepted item has its range mask and grouped used-bit search
// captured in the item registers; the maps update and the result register
// loads in the later commit step, which waits while the output register
// still holds an untaken result. One item is in flight at a time, set by
// the search-then-commit sequence over the map.
// When the receiver stalls, the result holds in the output register; the
// block still takes the next item and searches it, then waits before the
// commit until that result has been taken.
// Reset (rst_n low, synchronous): every block free, no pending blocks,
// index block zero, no open transaction, no result waiting.
module block_allocation_bitmap #(
  parameter int NUM_BLOCKS = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bam_pkg::FUNC_W-1:0]  in_func,
  input  logic [bam_pkg::BLK_W-1:0]   in_block,
  input  logic [bam_pkg::LEN_W-1:0]   in_length,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bam_pkg::STAT_W-1:0]  out_status,
  output logic [bam_pkg::BLK_W-1:0]   out_fault_block
);
  import bam_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequence accept, then commit
  bam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Maps, transaction tracking and the result register
  bam_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_block        (in_block),
    .in_length       (in_length),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_fault_block (out_fault_block)
  );

endmodule

>>> design/bam_checker.sv
`include "assert_macros.svh"

module bam_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [6:0] out_fault_block
);

  // stalled result holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_fault_block))

  // one item in flight: ready drops right after an accept
  `ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // with the result register empty, the commit does not stall and a result is produced for the accepted item
  `ASSERT_NXT(a_latency, clk, rst_n, in_valid && in_ready && !out_valid, ##1 out_valid)

  // no unused status code ever leaves the block
  `ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_status != 3'd7)

endmodule

bind block_allocation_bitmap bam_checker u_bam_checker (.*);
